// ----- rtl/smsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse MSR matrix-vector multiply: shared definitions
// Widths, vector store geometry and item operation codes.
// ----------------------------------------------------------------------------
package smsr_pkg;

  // Number of vector elements held in the local store.
  localparam int MAX_ROWS  = 4096;
  localparam int VEC_AW    = $clog2(MAX_ROWS);

  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = 48;

  // Wide enough to hold any item index and MAX_ROWS itself, so the range
  // check works for every store depth that fits in 17 bits.
  localparam int IDX_EXT_W = 17;

  // Item operation codes; the fourth code is unused and ignored.
  typedef enum logic [1:0] {
    OP_VEC_WRITE = 2'd0,
    OP_DIAG      = 2'd1,
    OP_OFFDIAG   = 2'd2
  } op_t;

endpackage : smsr_pkg
`default_nettype wire

// ----- rtl/smsr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse MSR matrix-vector multiply: stream channels
// Valid/ready channels for matrix and vector items and for row results.
// ----------------------------------------------------------------------------
interface smsr_in_if;
  import smsr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, output op, output index, output value, output last,
                  input ready);
  modport sink   (input valid, input op, input index, input value, input last,
                  output ready);
endinterface : smsr_in_if

interface smsr_out_if;
  import smsr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        row;
  logic signed [VAL_W-1:0] product;
  logic                    saturated;

  modport source (output valid, output row, output product, output saturated,
                  input ready);
  modport sink   (input valid, input row, input product, input saturated,
                  output ready);
endinterface : smsr_out_if
`default_nettype wire

// ----- rtl/sparse_msr_matrix_vector_multiply.sv -----
// The last item of a row passes step one and step two before its result loads the output register.
// Throughput: one item per cycle, set by the single vector store read port and the
// one 32x32 multiplier feeding the accumulator; the input stalls only while a row
// result is held back at the output. Reset (rst_n, synchronous, active low) clears
// the pipeline, the accumulator and the current row; the vector store is not cleared
// and needs no sweep, so items are taken from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse MSR matrix-vector multiply
// Streams a matrix in modified sparse row order against a locally stored
// dense vector and emits one saturated Q16.16 element of y per row.
// ----------------------------------------------------------------------------
module sparse_msr_matrix_vector_multiply (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smsr_in_if.sink     in_ch,
  smsr_out_if.source  out_ch
);
  import smsr_pkg::*;

  // The pipeline has three steps. At acceptance a vector write goes straight
  // into the store and a matrix entry issues its read of x. In the next step
  // the registered read data is ready and the multiplier forms the exact Q32.32 product.
  // In the last step the product is floored to Q32.16 and added into the
  // accumulator; an entry flagged last loads the output register.
  //
  // A write at acceptance lands before any later item's read is issued, so a
  // read of an element written by the item just before it sees the new value
  // without forwarding.

  // Vector store.
  logic [VAL_W-1:0] vec_mem [MAX_ROWS];
  logic [VAL_W-1:0] rd_data_r;

  // Step one: waiting for read data.
  logic                    s1_valid_r;
  logic                    s1_diag_r;
  logic                    s1_last_r;
  logic                    s1_inr_r;
  logic [IDX_W-1:0]        s1_row_r;
  logic signed [VAL_W-1:0] s1_val_r;

  // Step two: product ready for accumulation.
  logic                     s2_valid_r;
  logic                     s2_diag_r;
  logic                     s2_last_r;
  logic [IDX_W-1:0]         s2_row_r;
  logic signed [PROD_W-1:0] s2_prod_r;

  // Architectural state.
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0] cur_row_r, cur_row_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_row_r;
  logic signed [VAL_W-1:0] out_product_r;
  logic                    out_sat_r;

  logic                     adv;
  logic                     in_fire;
  logic                     s2_fire;
  logic                     emit;
  logic [IDX_EXT_W-1:0]     idx_ext;
  logic                     in_range;
  logic [VEC_AW-1:0]        vec_addr;
  logic                     is_write;
  logic                     is_entry;
  logic signed [VAL_W-1:0]  x_val;
  logic signed [PROD_W-1:0] mul_nxt;
  logic [ACC_W-1:0]         prod_q;
  logic [ACC_W-1:0]         acc_base;
  logic [ACC_W-1:0]         acc_sum;
  logic                     sum_sat;
  logic [VAL_W-1:0]         sum_clip;

  // The whole pipeline stops only when the row result in the last step
  // cannot be placed because the output register is still held.
  assign adv     = !(s2_valid_r && s2_last_r && out_valid_r && !out_ch.ready);
  assign in_ch.ready = adv;
  assign in_fire = in_ch.valid && adv;

  // Indices at or beyond the store depth are dropped on write and read as zero.
  assign idx_ext  = IDX_EXT_W'(in_ch.index);
  assign in_range = idx_ext < IDX_EXT_W'(MAX_ROWS);
  assign vec_addr = idx_ext[VEC_AW-1:0];

  always_comb begin
    is_write = 1'b0;
    is_entry = 1'b0;
    unique case (in_ch.op)
      OP_VEC_WRITE: is_write = 1'b1;
      OP_DIAG,
      OP_OFFDIAG:   is_entry = 1'b1;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_write && in_range) begin
      vec_mem[vec_addr] <= in_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= vec_mem[vec_addr];
    end
  end

  // Step one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_fire && is_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_diag_r <= (in_ch.op == OP_DIAG);
      s1_last_r <= in_ch.last;
      s1_inr_r  <= in_range;
      s1_row_r  <= in_ch.index;
      s1_val_r  <= in_ch.value;
    end
  end

  // Step two: multiply by the element, or by zero when out of range.
  assign x_val   = s1_inr_r ? $signed(rd_data_r) : '0;
  assign mul_nxt = s1_val_r * x_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_diag_r <= s1_diag_r;
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_prod_r <= mul_nxt;
    end
  end

  // Step three: dropping the low FRAC_W bits floors the product to Q32.16.
  assign s2_fire  = s2_valid_r && adv;
  assign emit     = s2_fire && s2_last_r;
  assign prod_q   = s2_prod_r[FRAC_W +: ACC_W];
  assign acc_base = s2_diag_r ? '0 : acc_r;
  assign acc_sum  = acc_base + prod_q;

  // The sum fits in 32 bits only when all bits from bit 31 upwards agree.
  assign sum_sat  = !((&acc_sum[ACC_W-1:VAL_W-1]) || !(|acc_sum[ACC_W-1:VAL_W-1]));
  assign sum_clip = acc_sum[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                     : {1'b0, {(VAL_W-1){1'b1}}};

  always_comb begin
    acc_nxt       = acc_r;
    cur_row_nxt   = cur_row_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s2_fire) begin
      if (s2_diag_r) begin
        cur_row_nxt = s2_row_r;
      end
      // A finished row leaves the accumulator at zero for stray entries.
      acc_nxt = s2_last_r ? '0 : acc_sum;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cur_row_r   <= cur_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r     <= s2_diag_r ? s2_row_r : cur_row_r;
      out_product_r <= sum_sat ? $signed(sum_clip) : $signed(acc_sum[VAL_W-1:0]);
      out_sat_r     <= sum_sat;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row       = out_row_r;
  assign out_ch.product   = out_product_r;
  assign out_ch.saturated = out_sat_r;

`ifndef SYNTH
  // A new result only ever comes from a last-flagged entry in the final step.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_last_r))
    else $error("result raised without a finishing entry");

  // Emitting a row always clears the accumulator.
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (acc_r == '0))
    else $error("accumulator not cleared after a row result");

  // A diagonal entry that completes sets the current row to its index.
  a_row_opened: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s2_diag_r) |=> (cur_row_r == $past(s2_row_r)))
    else $error("current row not taken from diagonal entry");

  // A result still waiting is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !emit)
    else $error("held result overwritten");
`endif

endmodule : sparse_msr_matrix_vector_multiply
`default_nettype wire

// ----- bench/sparse_msr_matrix_vector_multiply_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse MSR matrix-vector multiply: self-checking testbench
// Loads dense vector elements, then streams rows in modified sparse row
// order. Both channels idle and stall at random. Every accepted item is fed
// to a fixed-point row predictor, and every row result is checked against
// the oldest prediction.
// ----------------------------------------------------------------------------
module sparse_msr_matrix_vector_multiply_tb;
  import smsr_pkg::*;

  localparam int     CLK_PERIOD     = 12;
  localparam int     RESET_CYCLES   = 8;
  localparam int     RANDOM_ITEMS   = 1900;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     TAIL_CYCLES    = 12;
  localparam longint TIMEOUT_CYCLES = 400000;
  localparam int     IDLE_PERCENT   = 35;

  // The fourth operation code has no name in the package; the block ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [VAL_W-1:0] product;
    logic             saturated;
  } row_result_t;

  // Predicts the row results from the accepted items and checks the block's
  // results against them in order.
  class row_result_tracker;
    bit   [VAL_W-1:0] x_store [MAX_ROWS];
    logic [ACC_W-1:0] acc;
    logic [IDX_W-1:0] cur_row;
    row_result_t      expected_q[$];
    int unsigned      failures;

    function new();
      acc      = '0;
      cur_row  = '0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [VAL_W-1:0] element(logic [IDX_W-1:0] idx);
      if (int'(idx) >= MAX_ROWS)
        return '0;
      return x_store[idx];
    endfunction

    // Exact Q32.32 product, floored to Q32.16 and kept to accumulator width.
    function logic [ACC_W-1:0] scaled_product(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic signed [PROD_W-1:0] full;
      logic signed [PROD_W-1:0] floored;
      full    = $signed({{VAL_W{a[VAL_W-1]}}, a}) * $signed({{VAL_W{b[VAL_W-1]}}, b});
      floored = full >>> FRAC_W;
      return floored[ACC_W-1:0];
    endfunction

    function void close_row();
      longint      whole;
      row_result_t r;
      whole       = longint'($signed(acc));
      r.row       = cur_row;
      r.saturated = 1'b0;
      if (whole > Q_MAX) begin
        whole       = Q_MAX;
        r.saturated = 1'b1;
      end else if (whole < Q_MIN) begin
        whole       = Q_MIN;
        r.saturated = 1'b1;
      end
      r.product = whole[VAL_W-1:0];
      expected_q.push_back(r);
      acc = '0;
    endfunction

    function void take_item(logic [1:0] op, logic [IDX_W-1:0] idx,
                            logic [VAL_W-1:0] val, logic last);
      if (op == OP_VEC_WRITE) begin
        if (int'(idx) < MAX_ROWS)
          x_store[idx] = val;
      end else if (op == OP_DIAG || op == OP_OFFDIAG) begin
        if (op == OP_DIAG) begin
          cur_row = idx;
          acc     = scaled_product(val, element(idx));
        end else begin
          acc = acc + scaled_product(val, element(idx));
        end
        if (last)
          close_row();
      end
    endfunction

    function void check_row(logic [IDX_W-1:0] row, logic [VAL_W-1:0] product,
                            logic saturated);
      row_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected row result: row %0d, product 0x%08h", row, product);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (row !== exp_r.row) begin
        $error("row: expected %0d, got %0d", exp_r.row, row);
        failures++;
      end
      if (product !== exp_r.product) begin
        $error("product: expected 0x%08h, got 0x%08h", exp_r.product, product);
        failures++;
      end
      if (saturated !== exp_r.saturated) begin
        $error("saturated: expected %0b, got %0b", exp_r.saturated, saturated);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  smsr_in_if  in_ch ();
  smsr_out_if out_ch ();

  sparse_msr_matrix_vector_multiply i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  row_result_tracker tracker = new();

  // Vector elements that have been loaded; matrix entries only ever refer to
  // these, since a read of a never-written element is undefined.
  bit          stored [MAX_ROWS];
  int unsigned stored_idx[$];

  int unsigned items_sent;
  bit          steady_flow;
  bit          hold_req;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_VEC_WRITE;
    in_ch.index  <= '0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    out_ch.ready <= 1'b0;
  end

  // Result side: random back-pressure, none during the steady stretch, and
  // one long hold-off on request so that the block fills and stalls its input.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
        if (hold_left == 0)
          hold_req = 1'b0;
      end else if (hold_req) begin
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (steady_flow) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_row(out_ch.row, out_ch.product, out_ch.saturated);
  end

  // Called in the time step of a rising edge; returns in the time step of
  // the edge at which the item was accepted, or after an idle gap.
  task automatic idle_sender(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic last);
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.index <= idx;
    in_ch.value <= val;
    in_ch.last  <= last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    tracker.take_item(op, idx, val, last);
    if (op != OP_UNUSED)
      items_sent++;
    // Each further cycle is idle with the same chance, so the sender idles in
    // about that share of its cycles.
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
      idle_sender(1);
  endtask

  // Holds the input idle until every predicted result has been checked.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (tracker.pending() != 0);
  endtask

  task automatic load_element(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    send_item(OP_VEC_WRITE, idx, val, 1'($urandom_range(1)));
    if (!stored[idx]) begin
      stored[idx] = 1'b1;
      stored_idx.push_back(32'(idx));
    end
  endtask

  function automatic logic [IDX_W-1:0] any_stored();
    return IDX_W'(stored_idx[$urandom_range(stored_idx.size() - 1)]);
  endfunction

  // Mostly modest magnitudes so that rows land inside the Q16.16 range, with
  // pure fractions, full-range words and the extremes mixed in.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [31:0]  raw;
    int unsigned  sel;
    sel = $urandom_range(99);
    raw = $urandom;
    if (sel < 55)
      return VAL_W'($urandom_range(524288) - 262144);
    if (sel < 75)
      return $urandom_range(1) ? {16'hFFFF, raw[15:0]} : {16'h0000, raw[15:0]};
    if (sel < 93)
      return raw;
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_row(input int unsigned entries);
    logic [IDX_W-1:0] row_no;
    row_no = any_stored();
    send_item(OP_DIAG, row_no, pick_value(), entries == 0);
    for (int unsigned k = 1; k <= entries; k++)
      send_item(OP_OFFDIAG, any_stored(), pick_value(), k == entries);
  endtask

  initial begin : stimulus
    int unsigned sel;
    bit          hold_done;
    bit          drain_done;
    hold_done   = 1'b0;
    drain_done  = 1'b0;
    items_sent  = 0;
    steady_flow = 1'b0;
    hold_req    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, each operation and the corner cases.
    load_element(12'd0,    32'h7FFF_FFFF);
    load_element(12'd4095, 32'h8000_0000);
    load_element(12'd1,    32'h0001_0000);
    load_element(12'd2,    32'hFFFF_0000);
    load_element(12'd3,    32'h0000_0001);
    load_element(12'hAAA,  32'h0000_8000);
    load_element(12'h555,  32'hFFFF_8000);
    // Diagonal flagged last: the row is emitted at once.
    send_item(OP_DIAG, 12'd1, 32'h0001_0000, 1'b1);
    // Positive saturation.
    send_item(OP_DIAG,    12'd0, 32'h7FFF_FFFF, 1'b0);
    send_item(OP_OFFDIAG, 12'd0, 32'h7FFF_FFFF, 1'b1);
    // Three products of 2^46 wrap the accumulator to a negative value.
    send_item(OP_DIAG,    12'd4095, 32'h8000_0000, 1'b0);
    send_item(OP_OFFDIAG, 12'd4095, 32'h8000_0000, 1'b0);
    send_item(OP_OFFDIAG, 12'd4095, 32'h8000_0000, 1'b1);
    // Negative saturation.
    send_item(OP_DIAG,    12'd2, 32'h7FFF_FFFF, 1'b0);
    send_item(OP_OFFDIAG, 12'd2, 32'h7FFF_FFFF, 1'b1);
    // The smallest negative product floors to minus one LSB.
    send_item(OP_DIAG, 12'd3, 32'hFFFF_FFFF, 1'b1);
    // A diagonal while a row is open drops the unfinished row.
    send_item(OP_DIAG,    12'hAAA, 32'h0002_0000, 1'b0);
    send_item(OP_DIAG,    12'h555, 32'h0003_0000, 1'b0);
    send_item(OP_OFFDIAG, 12'hAAA, 32'h0001_0000, 1'b1);
    // A stray off-diagonal entry after a row has closed sums from zero.
    send_item(OP_OFFDIAG, 12'd1, 32'h0004_8000, 1'b1);
    // The unused operation code is ignored.
    send_item(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_UNUSED, 12'h000, 32'h0000_0000, 1'b0);

    // Random part: spread loaded elements over the whole index range first.
    items_sent = 0;
    repeat (48) load_element(IDX_W'($urandom), pick_value());
    while (items_sent < RANDOM_ITEMS) begin
      steady_flow = (items_sent >= 800 && items_sent < 1100);
      if (!hold_done && items_sent >= 500) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= 1300) begin
        drain_results();
        drain_done = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 12) begin
        load_element(IDX_W'($urandom), pick_value());
      end else if (sel < 80) begin
        if ($urandom_range(49) == 0)
          send_row($urandom_range(24));
        else
          send_row($urandom_range(6));
      end else if (sel < 88) begin
        // Broken row: not closed here, so the next diagonal drops it unless a stray last entry closes it.
        send_item(OP_DIAG, any_stored(), pick_value(), 1'b0);
        repeat ($urandom_range(2))
          send_item(OP_OFFDIAG, any_stored(), pick_value(), 1'b0);
      end else if (sel < 94) begin
        send_item(OP_OFFDIAG, any_stored(), pick_value(), 1'($urandom_range(1)));
      end else begin
        send_item(OP_UNUSED, IDX_W'($urandom), $urandom, 1'($urandom_range(1)));
      end
    end
    steady_flow = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

endmodule : sparse_msr_matrix_vector_multiply_tb
